@@ rtl/core/txp_pkg.sv @@
`timescale 1ns / 1ps

package txp_pkg;

    localparam int ID_BYTES_DEF = 32;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] PFX_2B = 8'hfd;
    localparam logic [7:0] PFX_4B = 8'hfe;

    typedef enum logic [3:0] {
        K_COUNT  = 4'd0,
        K_ID     = 4'd1,
        K_INDEX  = 4'd2,
        K_SLEN   = 4'd3,
        K_SBYTE  = 4'd4,
        K_SEQ    = 4'd5,
        K_AMOUNT = 4'd6,
        K_DONE   = 4'd7,
        K_TRUNC  = 4'd8
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  field_kind;
        logic [63:0] field_value;
        logic [63:0] entry_number;
        logic        last_of_run;
    } t_out_word;

    // One entry of the queue between the parser and the result sequencer.
    typedef struct packed {
        logic        burst;
        t_kind       a_kind;
        logic [63:0] a_value;
        logic [63:0] a_entry;
        logic        has_b;
        t_kind       b_kind;
        logic [63:0] b_entry;
    } t_cmd;

endpackage

@@ rtl/core/txp_cmd_fifo.sv @@
`timescale 1ns / 1ps

module txp_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  txp_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_valid,
    output txp_pkg::t_cmd o_data,
    input  logic          i_pop
);

    txp_pkg::t_cmd                 r_mem [txp_pkg::QUEUE_DEPTH];
    logic [txp_pkg::QPTR_W-1:0]    r_wptr;
    logic [txp_pkg::QPTR_W-1:0]    r_rptr;
    logic [txp_pkg::QPTR_W:0]      r_count;
    logic                          wr;
    logic                          rd;

    assign o_full  = (r_count == (txp_pkg::QPTR_W+1)'(txp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (wr) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/txp_front.sv @@
`timescale 1ns / 1ps

module txp_front #(
    parameter int  ID_BYTES = txp_pkg::ID_BYTES_DEF,
    localparam int IDW      = $clog2(ID_BYTES > 1 ? ID_BYTES : 2)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              i_push,
    output logic              o_full,
    input  txp_pkg::t_in_word i_in_word,
    output logic              o_cmd_push,
    output txp_pkg::t_cmd     o_cmd,
    input  logic              i_q_full,
    output logic              o_id_we,
    output logic [IDW-1:0]    o_id_waddr,
    output logic [7:0]        o_id_wdata,
    input  logic              i_burst_done
);

    typedef enum logic [11:0] {
        PH_CNT_PFX = 12'b0000_0000_0001,
        PH_CNT_EXT = 12'b0000_0000_0010,
        PH_ID      = 12'b0000_0000_0100,
        PH_INDEX   = 12'b0000_0000_1000,
        PH_ISL_PFX = 12'b0000_0001_0000,
        PH_ISL_EXT = 12'b0000_0010_0000,
        PH_ISCRIPT = 12'b0000_0100_0000,
        PH_SEQ     = 12'b0000_1000_0000,
        PH_AMOUNT  = 12'b0001_0000_0000,
        PH_OSL_PFX = 12'b0010_0000_0000,
        PH_OSL_EXT = 12'b0100_0000_0000,
        PH_OSCRIPT = 12'b1000_0000_0000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [5:0]    r_fcnt, n_fcnt;
    logic [63:0]   r_acc, n_acc;
    logic [3:0]    r_pwidth, n_pwidth;
    logic [63:0]   r_left, n_left;
    logic [63:0]   r_entry, n_entry;
    logic [63:0]   r_sleft, n_sleft;
    logic          r_stopped, n_stopped;
    logic          r_list_kind;
    logic          r_busy, n_busy;

    logic          take;
    logic [7:0]    b;
    logic [63:0]   b64;
    logic [63:0]   acc_take;
    logic [5:0]    fcnt_inc;
    logic          take_done;
    logic          pfx_short;
    logic [3:0]    pfx_width;
    logic [63:0]   left_dec;
    logic [63:0]   sleft_dec;
    logic [63:0]   entry_inc;

    logic          cnt_known;
    logic          slen_known;
    logic          slen_out;
    logic [63:0]   known_val;
    logic          do_finish;
    logic          do_begin;
    logic          have_a;
    logic          id_we;
    txp_pkg::t_cmd cmd;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_q_full || ((r_phase == PH_ID) && r_busy);
    assign take        = i_push && !o_full;
    assign b           = i_in_word.data_byte;
    assign b64         = {56'h0, b};
    assign fcnt_inc    = r_fcnt + 6'd1;
    assign take_done   = fcnt_inc >= {2'b00, r_pwidth};
    assign pfx_short   = b < txp_pkg::PFX_2B;
    assign pfx_width   = (b == txp_pkg::PFX_2B) ? 4'd2 :
                         (b == txp_pkg::PFX_4B) ? 4'd4 : 4'd8;
    assign left_dec    = r_left - 64'd1;
    assign sleft_dec   = r_sleft - 64'd1;
    assign entry_inc   = r_entry + 64'd1;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            acc_take[8*k +: 8] = r_acc[8*k +: 8] | ((r_fcnt[2:0] == 3'(k)) ? b : 8'h00);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_fcnt     = r_fcnt;
        n_acc      = r_acc;
        n_pwidth   = r_pwidth;
        n_left     = r_left;
        n_entry    = r_entry;
        n_sleft    = r_sleft;
        n_stopped  = r_stopped;
        cnt_known  = 1'b0;
        slen_known = 1'b0;
        slen_out   = 1'b0;
        known_val  = 64'h0;
        do_finish  = 1'b0;
        do_begin   = 1'b0;
        have_a     = 1'b0;
        id_we      = 1'b0;
        cmd        = '0;
        if (take && !r_stopped) begin
            case (r_phase)
                PH_CNT_PFX: begin
                    if (pfx_short) begin
                        cnt_known = 1'b1;
                        known_val = b64;
                        n_acc     = b64;
                    end else begin
                        n_phase  = PH_CNT_EXT;
                        n_fcnt   = 6'd0;
                        n_acc    = 64'h0;
                        n_pwidth = pfx_width;
                    end
                end
                PH_CNT_EXT: begin
                    n_fcnt = fcnt_inc;
                    n_acc  = acc_take;
                    if (take_done) begin
                        cnt_known = 1'b1;
                        known_val = acc_take;
                    end
                end
                PH_ID: begin
                    id_we  = r_fcnt < 6'(ID_BYTES);
                    n_fcnt = fcnt_inc;
                    if (fcnt_inc >= 6'(ID_BYTES)) begin
                        cmd.burst   = 1'b1;
                        cmd.a_entry = r_entry;
                        n_phase     = PH_INDEX;
                        n_fcnt      = 6'd0;
                        n_acc       = 64'h0;
                        n_pwidth    = 4'd4;
                    end
                end
                PH_INDEX: begin
                    n_fcnt = fcnt_inc;
                    n_acc  = acc_take;
                    if (take_done) begin
                        have_a      = 1'b1;
                        cmd.a_kind  = txp_pkg::K_INDEX;
                        cmd.a_value = acc_take;
                        cmd.a_entry = r_entry;
                        n_phase     = PH_ISL_PFX;
                    end
                end
                PH_ISL_PFX, PH_OSL_PFX: begin
                    if (pfx_short) begin
                        slen_known = 1'b1;
                        slen_out   = (r_phase == PH_OSL_PFX);
                        known_val  = b64;
                        n_acc      = b64;
                    end else begin
                        n_phase  = (r_phase == PH_OSL_PFX) ? PH_OSL_EXT : PH_ISL_EXT;
                        n_fcnt   = 6'd0;
                        n_acc    = 64'h0;
                        n_pwidth = pfx_width;
                    end
                end
                PH_ISL_EXT, PH_OSL_EXT: begin
                    n_fcnt = fcnt_inc;
                    n_acc  = acc_take;
                    if (take_done) begin
                        slen_known = 1'b1;
                        slen_out   = (r_phase == PH_OSL_EXT);
                        known_val  = acc_take;
                    end
                end
                PH_ISCRIPT, PH_OSCRIPT: begin
                    have_a      = 1'b1;
                    cmd.a_kind  = txp_pkg::K_SBYTE;
                    cmd.a_value = b64;
                    cmd.a_entry = r_entry;
                    n_sleft     = sleft_dec;
                    if (sleft_dec == 64'h0) begin
                        if (r_phase == PH_OSCRIPT) begin
                            do_finish = 1'b1;
                        end else begin
                            n_phase  = PH_SEQ;
                            n_fcnt   = 6'd0;
                            n_acc    = 64'h0;
                            n_pwidth = 4'd4;
                        end
                    end
                end
                PH_SEQ: begin
                    n_fcnt = fcnt_inc;
                    n_acc  = acc_take;
                    if (take_done) begin
                        have_a      = 1'b1;
                        cmd.a_kind  = txp_pkg::K_SEQ;
                        cmd.a_value = acc_take;
                        cmd.a_entry = r_entry;
                        do_finish   = 1'b1;
                    end
                end
                PH_AMOUNT: begin
                    n_fcnt = fcnt_inc;
                    n_acc  = acc_take;
                    if (take_done) begin
                        have_a      = 1'b1;
                        cmd.a_kind  = txp_pkg::K_AMOUNT;
                        cmd.a_value = acc_take;
                        cmd.a_entry = r_entry;
                        n_phase     = PH_OSL_PFX;
                    end
                end
                default: begin
                    n_phase = PH_CNT_PFX;
                end
            endcase

            if (cnt_known) begin
                have_a      = 1'b1;
                cmd.a_kind  = txp_pkg::K_COUNT;
                cmd.a_value = known_val;
                cmd.a_entry = 64'h0;
                n_left      = known_val;
                n_entry     = 64'h0;
                if (known_val == 64'h0) begin
                    cmd.has_b   = 1'b1;
                    cmd.b_kind  = txp_pkg::K_DONE;
                    cmd.b_entry = 64'h0;
                    n_stopped   = 1'b1;
                end else begin
                    do_begin = 1'b1;
                end
            end

            if (slen_known) begin
                have_a      = 1'b1;
                cmd.a_kind  = txp_pkg::K_SLEN;
                cmd.a_value = known_val;
                cmd.a_entry = r_entry;
                n_sleft     = known_val;
                if (known_val != 64'h0) begin
                    n_phase = slen_out ? PH_OSCRIPT : PH_ISCRIPT;
                end else if (slen_out) begin
                    do_finish = 1'b1;
                end else begin
                    n_phase  = PH_SEQ;
                    n_fcnt   = 6'd0;
                    n_acc    = 64'h0;
                    n_pwidth = 4'd4;
                end
            end

            if (do_finish) begin
                n_entry = entry_inc;
                n_left  = left_dec;
                if (left_dec == 64'h0) begin
                    cmd.has_b   = 1'b1;
                    cmd.b_kind  = txp_pkg::K_DONE;
                    cmd.b_entry = entry_inc;
                    n_stopped   = 1'b1;
                end else begin
                    do_begin = 1'b1;
                end
            end

            if (do_begin) begin
                if (r_list_kind) begin
                    n_phase  = PH_AMOUNT;
                    n_fcnt   = 6'd0;
                    n_acc    = 64'h0;
                    n_pwidth = 4'd8;
                end else begin
                    n_phase = PH_ID;
                    n_fcnt  = 6'd0;
                end
            end

            // A partially received field is dropped when the buffer ends.
            if (i_in_word.end_of_buffer && !n_stopped) begin
                n_stopped = 1'b1;
                if (have_a || cmd.burst) begin
                    cmd.has_b   = 1'b1;
                    cmd.b_kind  = txp_pkg::K_TRUNC;
                    cmd.b_entry = n_entry;
                end else begin
                    have_a      = 1'b1;
                    cmd.a_kind  = txp_pkg::K_TRUNC;
                    cmd.a_value = 64'h0;
                    cmd.a_entry = n_entry;
                end
            end
        end
    end

    assign o_cmd      = cmd;
    assign o_cmd_push = take && !r_stopped && (have_a || cmd.burst);
    assign o_id_we    = id_we;
    assign o_id_waddr = r_fcnt[IDW-1:0];
    assign o_id_wdata = b;

    always_comb begin
        n_busy = r_busy;
        if (o_cmd_push && cmd.burst) begin
            n_busy = 1'b1;
        end else if (i_burst_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_CNT_PFX;
            r_fcnt      <= '0;
            r_acc       <= '0;
            r_pwidth    <= '0;
            r_left      <= '0;
            r_entry     <= '0;
            r_sleft     <= '0;
            r_stopped   <= 1'b0;
            r_list_kind <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_fcnt    <= n_fcnt;
            r_acc     <= n_acc;
            r_pwidth  <= n_pwidth;
            r_left    <= n_left;
            r_entry   <= n_entry;
            r_sleft   <= n_sleft;
            r_stopped <= n_stopped;
            r_busy    <= n_busy;
            if (i_cfg_valid && o_cfg_ready) begin
                r_list_kind <= i_cfg_data;
            end
        end
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_push |-> !i_q_full)
        else $error("command pushed into a full queue");

    a_id_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_id_we |-> !r_busy)
        else $error("id buffer written while a reversed burst is pending");

    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("parser left the stopped state without reset");

endmodule

@@ rtl/core/txp_back.sv @@
`timescale 1ns / 1ps

module txp_back #(
    parameter int  ID_BYTES = txp_pkg::ID_BYTES_DEF,
    localparam int IDW      = $clog2(ID_BYTES > 1 ? ID_BYTES : 2)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  txp_pkg::t_cmd      i_q_data,
    output logic               o_q_pop,
    input  logic               i_id_we,
    input  logic [IDW-1:0]     i_id_waddr,
    input  logic [7:0]         i_id_wdata,
    output logic               o_burst_done,
    output logic               o_empty,
    input  logic               i_pop,
    output txp_pkg::t_out_word o_out_word
);

    typedef enum logic [2:0] {
        S_HEAD  = 3'b001,
        S_BURST = 3'b010,
        S_TAIL  = 3'b100
    } t_state;

    localparam logic [IDW-1:0] LAST = IDW'(ID_BYTES - 1);

    t_state             r_state, n_state;
    txp_pkg::t_cmd      r_cmd, n_cmd;
    logic [IDW-1:0]     r_idx, n_idx;
    logic [7:0]         r_rd;
    logic [7:0]         r_mem [ID_BYTES];
    txp_pkg::t_out_word r_out, n_out;
    logic               r_out_valid;
    logic               out_free;
    logic               emit;

    assign out_free = !r_out_valid || i_pop;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_idx        = r_idx;
        n_out        = r_out;
        emit         = 1'b0;
        o_q_pop      = 1'b0;
        o_burst_done = 1'b0;
        case (r_state)
            S_HEAD: begin
                if (i_q_valid && (i_q_data.burst || out_free)) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_data;
                    if (i_q_data.burst) begin
                        n_state = S_BURST;
                        n_idx   = LAST;
                    end else begin
                        emit               = 1'b1;
                        n_out.field_kind   = i_q_data.a_kind;
                        n_out.field_value  = i_q_data.a_value;
                        n_out.entry_number = i_q_data.a_entry;
                        n_out.last_of_run  = !i_q_data.has_b;
                        if (i_q_data.has_b) begin
                            n_state = S_TAIL;
                        end
                    end
                end
            end
            S_BURST: begin
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.field_kind   = txp_pkg::K_ID;
                    n_out.field_value  = {56'h0, r_rd};
                    n_out.entry_number = r_cmd.a_entry;
                    n_out.last_of_run  = (r_idx == '0) && !r_cmd.has_b;
                    if (r_idx == '0) begin
                        o_burst_done = 1'b1;
                        n_state      = r_cmd.has_b ? S_TAIL : S_HEAD;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            S_TAIL: begin
                if (out_free) begin
                    emit               = 1'b1;
                    n_out.field_kind   = r_cmd.b_kind;
                    n_out.field_value  = 64'h0;
                    n_out.entry_number = r_cmd.b_entry;
                    n_out.last_of_run  = 1'b1;
                    n_state            = S_HEAD;
                end
            end
            default: begin
                n_state = S_HEAD;
            end
        endcase
    end

    // The read address runs one step ahead so the byte is registered when it is needed.
    always_ff @(posedge i_clk) begin
        if (i_id_we) begin
            r_mem[i_id_waddr] <= i_id_wdata;
        end
        r_rd <= r_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_HEAD;
            r_idx       <= LAST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_word = r_out;

    a_burst_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BURST) |-> r_cmd.burst)
        else $error("reversed id burst running without a burst command");

    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_burst_done |=> (r_state != S_BURST))
        else $error("burst still running after its last id byte");

endmodule

@@ rtl/core/tx_input_output_list_parser.sv @@
`timescale 1ns / 1ps
// A result word is registered in the command queue and then in the output register;
// the first word of a reversed id also passes the S_BURST state and the id buffer read register.
// Throughput: one byte per cycle while each byte gives at most one word and the queue has room.
// The sequencer emits one word per cycle while the output is free; a byte with two words holds it
// for both, and the next id waits at its first byte while the last id goes out reversed.
// Synchronous active-low reset clears the parser, the queue and the output, not the id buffer.
module tx_input_output_list_parser #(
    parameter int ID_BYTES = txp_pkg::ID_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  txp_pkg::t_in_word  i_in_word,
    output logic               empty,
    input  logic               pop,
    output txp_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);

    localparam int IDW = $clog2(ID_BYTES > 1 ? ID_BYTES : 2);

    txp_pkg::t_cmd  f_cmd;
    logic           f_cmd_push;
    logic           q_full;
    logic           q_valid;
    txp_pkg::t_cmd  q_data;
    logic           q_pop;
    logic           id_we;
    logic [IDW-1:0] id_waddr;
    logic [7:0]     id_wdata;
    logic           burst_done;

    txp_front #(
        .ID_BYTES (ID_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .i_push       (push),
        .o_full       (full),
        .i_in_word    (i_in_word),
        .o_cmd_push   (f_cmd_push),
        .o_cmd        (f_cmd),
        .i_q_full     (q_full),
        .o_id_we      (id_we),
        .o_id_waddr   (id_waddr),
        .o_id_wdata   (id_wdata),
        .i_burst_done (burst_done)
    );

    txp_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_cmd_push),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    txp_back #(
        .ID_BYTES (ID_BYTES)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_data     (q_data),
        .o_q_pop      (q_pop),
        .i_id_we      (id_we),
        .i_id_waddr   (id_waddr),
        .i_id_wdata   (id_wdata),
        .o_burst_done (burst_done),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_out_word   (o_out_word)
    );

endmodule
